/* src/tsfq_pkg.sv */
// Shared types and codes for the two-stack FIFO queue.
// No dependencies; used by the controller, the datapath and the top level.
package tsfq_pkg;

	// Requested operation
	typedef enum logic {
		OP_PUSH = 1'b0,
		OP_POP  = 1'b1
	} op_t;

	// Result status codes
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic    load_req;  // capture the push word of an accepted request
		logic    mv_rd;     // read top of input stack, drop input count
		logic    mv_wr;     // write read word onto output stack, bump output count
		logic    push_wr;   // write push word onto input stack
		logic    pop_rd;    // read top of output stack, drop output count
		logic    res_load;  // load the result register
		logic    res_pop;   // result carries the popped word
		status_t res_status;
	} ctrl_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic in_full;
		logic in_empty;
		logic out_empty;
		logic res_busy;   // result register holds an untaken result
	} dp_flags_t;

endpackage

/* src/tsfq_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tsfq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8
) (
	input  logic                                 clk,
	input  logic                                 we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                     wdata,
	input  logic                                 re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                     rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port, registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* src/tsfq_ctrl.sv */
// Controller state machine for the two-stack FIFO queue.
// Depends on tsfq_pkg; drives the datapath by command and status structs.
module tsfq_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  cmd,
	input  tsfq_pkg::dp_flags_t   flags,
	output tsfq_pkg::ctrl_cmd_t   ctl
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_MOVE,
		S_PUSH,
		S_POP,
		S_FINISH
	} state_t;

	state_t              state_q;
	tsfq_pkg::op_t       op_q;
	tsfq_pkg::status_t   stat_q;
	logic                pend_q;
	logic                accept;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;

	// Decode commands from the current state
	always_comb begin
		ctl            = '0;
		ctl.load_req   = accept;
		ctl.mv_rd      = (state_q == S_MOVE) && !flags.in_empty;
		ctl.mv_wr      = (state_q == S_MOVE) && pend_q;
		ctl.push_wr    = (state_q == S_PUSH);
		ctl.pop_rd     = (state_q == S_POP);
		ctl.res_load   = (state_q == S_FINISH) && !flags.res_busy;
		ctl.res_pop    = (op_q == tsfq_pkg::OP_POP) && (stat_q == tsfq_pkg::ST_OK);
		ctl.res_status = stat_q;
	end

	// Sequence one request: decide, transfer if needed, operate unless refused or empty, report
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q    <= tsfq_pkg::OP_PUSH;
			stat_q  <= tsfq_pkg::ST_OK;
			pend_q  <= 1'b0;
		end else begin
			pend_q <= (state_q == S_MOVE) && !flags.in_empty;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						stat_q <= tsfq_pkg::ST_OK;
						if (cmd == tsfq_pkg::OP_POP) begin
							op_q <= tsfq_pkg::OP_POP;
							if (flags.in_empty && flags.out_empty) begin
								stat_q  <= tsfq_pkg::ST_EMPTY;
								state_q <= S_FINISH;
							end else if (flags.out_empty) begin
								state_q <= S_MOVE;
							end else begin
								state_q <= S_POP;
							end
						end else begin
							op_q <= tsfq_pkg::OP_PUSH;
							if (flags.in_full && !flags.out_empty) begin
								stat_q  <= tsfq_pkg::ST_FULL;
								state_q <= S_FINISH;
							end else if (flags.in_full) begin
								state_q <= S_MOVE;
							end else begin
								state_q <= S_PUSH;
							end
						end
					end
				end
				S_MOVE: begin
					// leave once the last read word has been written
					if (flags.in_empty && !pend_q) begin
						state_q <= (op_q == tsfq_pkg::OP_POP) ? S_POP : S_PUSH;
					end
				end
				S_PUSH: begin
					state_q <= S_FINISH;
				end
				S_POP: begin
					state_q <= S_FINISH;
				end
				S_FINISH: begin
					if (!flags.res_busy) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

/* src/tsfq_datapath.sv */
// Datapath for the two-stack FIFO queue: both stacks, counts and result register.
// Depends on tsfq_pkg and tsfq_ram.
module tsfq_datapath #(
	parameter int STACK_DEPTH = 8,
	parameter int DATA_WIDTH  = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tsfq_pkg::ctrl_cmd_t  ctl,
	output tsfq_pkg::dp_flags_t  flags,
	input  logic [31:0]          push_value,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [31:0]          pop_value,
	output logic [1:0]           status,
	output logic [4:0]           occupancy
);

	localparam int AW    = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int CNT_W = $clog2(STACK_DEPTH + 1);
	localparam int OCC_W = CNT_W + 1;

	logic [CNT_W-1:0]      in_cnt_q;
	logic [CNT_W-1:0]      out_cnt_q;
	logic [CNT_W-1:0]      in_top;
	logic [CNT_W-1:0]      out_top;
	logic [OCC_W-1:0]      occ_sum;
	logic [DATA_WIDTH-1:0] val_q;
	logic [DATA_WIDTH-1:0] in_rdata;
	logic [DATA_WIDTH-1:0] out_rdata;
	logic                  out_valid_q;

	assign in_top  = in_cnt_q - 1'b1;
	assign out_top = out_cnt_q - 1'b1;
	assign occ_sum = OCC_W'(in_cnt_q) + OCC_W'(out_cnt_q);

	// Report stack and result status to the controller
	always_comb begin
		flags.in_full   = (in_cnt_q == CNT_W'(STACK_DEPTH));
		flags.in_empty  = (in_cnt_q == '0);
		flags.out_empty = (out_cnt_q == '0);
		flags.res_busy  = out_valid_q && !out_ready;
	end

	assign out_valid = out_valid_q;

	// Hold the push word of the accepted request
	always_ff @(posedge clk) begin
		if (ctl.load_req) begin
			val_q <= DATA_WIDTH'(push_value);
		end
	end

	// Input stack
	tsfq_ram #(
		.WIDTH (DATA_WIDTH),
		.DEPTH (STACK_DEPTH)
	) u_in_stack (
		.clk   (clk),
		.we    (ctl.push_wr),
		.waddr (in_cnt_q[AW-1:0]),
		.wdata (val_q),
		.re    (ctl.mv_rd),
		.raddr (in_top[AW-1:0]),
		.rdata (in_rdata)
	);

	// Output stack, filled from the input stack's read data
	tsfq_ram #(
		.WIDTH (DATA_WIDTH),
		.DEPTH (STACK_DEPTH)
	) u_out_stack (
		.clk   (clk),
		.we    (ctl.mv_wr),
		.waddr (out_cnt_q[AW-1:0]),
		.wdata (in_rdata),
		.re    (ctl.pop_rd),
		.raddr (out_top[AW-1:0]),
		.rdata (out_rdata)
	);

	// Advance stack counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_cnt_q  <= '0;
			out_cnt_q <= '0;
		end else begin
			if (ctl.push_wr) begin
				in_cnt_q <= in_cnt_q + 1'b1;
			end else if (ctl.mv_rd) begin
				in_cnt_q <= in_top;
			end
			if (ctl.mv_wr) begin
				out_cnt_q <= out_cnt_q + 1'b1;
			end else if (ctl.pop_rd) begin
				out_cnt_q <= out_top;
			end
		end
	end

	// Result valid: set on load, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.res_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (ctl.res_load) begin
			pop_value <= ctl.res_pop ? 32'(out_rdata) : 32'd0;
			status    <= ctl.res_status;
			occupancy <= 5'(occ_sum);
		end
	end

	// Counts never pass the stack depth
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(in_cnt_q <= CNT_W'(STACK_DEPTH)) && (out_cnt_q <= CNT_W'(STACK_DEPTH)))
		else $error("stack count beyond depth");

	// A push write never lands on a full input stack
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.push_wr |-> !flags.in_full)
		else $error("push on full input stack");

	// A pop read never targets an empty output stack
	a_pop_data: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.pop_rd |-> !flags.out_empty)
		else $error("pop on empty output stack");

	// Each transfer write follows a transfer read in the previous cycle
	a_move_pair: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.mv_wr |-> $past(ctl.mv_rd))
		else $error("transfer write without read");

endmodule

/* src/two_stack_fifo_queue.sv */
// Top level of the two-stack FIFO queue: controller plus datapath.
// Depends on tsfq_pkg, tsfq_ctrl, tsfq_datapath and tsfq_ram.
//
// FIFO queue built from an input and an output stack of STACK_DEPTH words
// each. One request (push or pop) is taken at a time and gives one result
// with status and total occupancy. A request that needs no transfer passes from
// acceptance through its push or pop state to the finish state, which loads the
// result; the next request can be taken after that. A refused push or an empty
// pop goes from acceptance straight to the finish state. When a push meets a
// full input stack with an empty output stack, or a pop meets an empty output
// stack, the input stack is first moved onto the output stack. The move goes
// one word per cycle through the stack RAMs' registered read port. A full push
// with data still in the output stack is refused with status 1. A pop on an
// empty queue gives status 2. The result register lets the next request be
// taken while a result waits. That request's result then holds until the
// waiting one is taken.
module two_stack_fifo_queue #(
	parameter int STACK_DEPTH = 8,
	parameter int DATA_WIDTH  = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        cmd,
	input  logic [31:0] push_value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] pop_value,
	output logic [1:0]  status,
	output logic [4:0]  occupancy
);

	tsfq_pkg::ctrl_cmd_t ctl;
	tsfq_pkg::dp_flags_t flags;

	tsfq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.cmd      (cmd),
		.flags    (flags),
		.ctl      (ctl)
	);

	tsfq_datapath #(
		.STACK_DEPTH (STACK_DEPTH),
		.DATA_WIDTH  (DATA_WIDTH)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.flags      (flags),
		.push_value (push_value),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.pop_value  (pop_value),
		.status     (status),
		.occupancy  (occupancy)
	);

endmodule

/* dv/tb_two_stack_fifo_queue.sv */
`timescale 1ns / 100ps
// Testbench for two_stack_fifo_queue: random and directed push/pop requests,
// each result checked against an in-bench two-stack predictor.
// Depends on tsfq_pkg and the two_stack_fifo_queue RTL.
module tb_two_stack_fifo_queue;

	localparam int DEPTH       = 8;
	localparam int RAND_REQS   = 1526;
	localparam int HOLD_AT     = 400;    // result count that starts the long receiver hold
	localparam int HOLD_CYCLES = 250;
	localparam int LIMIT       = 400000;

	typedef struct {
		tsfq_pkg::op_t op;
		logic [31:0]   word;
		int            gap;
		bit            drain;   // wait for every outstanding result before sending
	} queue_req_t;

	typedef struct {
		logic [31:0]       word;
		tsfq_pkg::status_t st;
		logic [4:0]        occ;
	} queue_res_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        cmd = 1'b0;
	logic [31:0] push_value = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [31:0] pop_value;
	logic [1:0]  status;
	logic [4:0]  occupancy;

	two_stack_fifo_queue #(
		.STACK_DEPTH(DEPTH),
		.DATA_WIDTH (32)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.cmd       (cmd),
		.push_value(push_value),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.pop_value (pop_value),
		.status    (status),
		.occupancy (occupancy)
	);

	always #10 clk = ~clk;

	// Predictor state: mirror of both stacks
	logic [31:0] in_words [DEPTH];
	logic [31:0] out_words [DEPTH];
	int          in_fill = 0;
	int          out_fill = 0;

	queue_req_t  pending_reqs [$];
	queue_res_t  expected_results [$];
	int          total_reqs = 0;
	int          taken_reqs = 0;
	int          results_seen = 0;
	int          mismatches = 0;
	int          cycles = 0;
	logic        req_taken = 1'b0;
	logic        res_taken = 1'b0;

	// Reverse the input stack onto the (empty) output stack
	function automatic void shift_stacks();
		while (in_fill > 0 && out_fill < DEPTH) begin
			in_fill--;
			out_words[out_fill] = in_words[in_fill];
			out_fill++;
		end
	endfunction

	// Apply one request to the mirrored stacks and return its result
	function automatic queue_res_t queue_apply(tsfq_pkg::op_t op, logic [31:0] word);
		queue_res_t r;
		r.word = '0;
		r.st   = tsfq_pkg::ST_OK;
		if (op == tsfq_pkg::OP_PUSH) begin
			if (in_fill >= DEPTH && out_fill > 0) begin
				r.st = tsfq_pkg::ST_FULL;
			end else begin
				if (in_fill >= DEPTH)
					shift_stacks();
				in_words[in_fill] = word;
				in_fill++;
			end
		end else begin
			if (in_fill == 0 && out_fill == 0) begin
				r.st = tsfq_pkg::ST_EMPTY;
			end else begin
				if (out_fill == 0)
					shift_stacks();
				out_fill--;
				r.word = out_words[out_fill];
			end
		end
		r.occ = 5'(in_fill + out_fill);
		return r;
	endfunction

	function automatic void add_req(tsfq_pkg::op_t op, logic [31:0] word, int gap, bit drain);
		queue_req_t q;
		q.op    = op;
		q.word  = word;
		q.gap   = gap;
		q.drain = drain;
		pending_reqs.push_back(q);
		total_reqs++;
	endfunction

	// Request driver: hold until accepted, then wait the drawn gap
	int         gap_left = 0;
	bit         gap_armed = 1'b0;
	queue_req_t cur_req;
	always @(negedge clk) begin
		logic nxt_valid;
		if (arst_n) begin
			nxt_valid = in_valid;
			if (!in_valid || req_taken) begin
				nxt_valid = 1'b0;
				if (pending_reqs.size() > 0) begin
					if (!gap_armed) begin
						gap_left  = pending_reqs[0].gap;
						gap_armed = 1'b1;
					end
					if (gap_left > 0) begin
						gap_left--;
					end else if (!(pending_reqs[0].drain && expected_results.size() != 0)) begin
						cur_req    = pending_reqs.pop_front();
						cmd        <= cur_req.op;
						push_value <= cur_req.word;
						nxt_valid  = 1'b1;
						gap_armed  = 1'b0;
					end
				end
			end
			in_valid <= nxt_valid;
		end
	end

	// Result receiver: random stalls, quiet stretches, one long hold-off
	int rx_wait = 0;
	int long_hold = 0;
	bit hold_done = 1'b0;
	always @(negedge clk) begin
		logic nxt_ready;
		if (arst_n) begin
			nxt_ready = out_ready;
			if (long_hold > 0) begin
				long_hold--;
				nxt_ready = (long_hold == 0);
			end else if (!hold_done && results_seen >= HOLD_AT) begin
				hold_done = 1'b1;
				long_hold = HOLD_CYCLES;
				nxt_ready = 1'b0;
			end else if (res_taken || !out_ready) begin
				if (res_taken)
					rx_wait = ((results_seen / 128) % 4 == 3) ? 0 : $urandom_range(0, 14);
				else if (rx_wait > 0)
					rx_wait--;
				nxt_ready = (rx_wait == 0);
			end
			out_ready <= nxt_ready;
		end
	end

	// Monitor: check results first, then predict newly accepted requests
	always @(posedge clk) begin
		queue_res_t got;
		queue_res_t want;
		req_taken <= arst_n && in_valid && in_ready;
		res_taken <= arst_n && out_valid && out_ready;
		if (arst_n && out_valid && out_ready) begin
			got.word = pop_value;
			got.st   = tsfq_pkg::status_t'(status);
			got.occ  = occupancy;
			results_seen++;
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %0d: value %h status %0d occupancy %0d",
						results_seen, got.word, got.st, got.occ);
			end else begin
				want = expected_results.pop_front();
				if (got.word !== want.word || got.st !== want.st || got.occ !== want.occ) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result %0d: expected %h/%0d/%0d, got %h/%0d/%0d",
							results_seen, want.word, want.st, want.occ,
							got.word, got.st, got.occ);
				end
			end
		end
		if (arst_n && in_valid && in_ready) begin
			expected_results.push_back(queue_apply(tsfq_pkg::op_t'(cmd), push_value));
			taken_reqs++;
		end
	end

	// Timeout guard
	always @(posedge clk) begin
		cycles++;
		if (cycles == LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// Stimulus and end of test
	initial begin
		int pop_pct;
		int gap_mode;
		int gap;
		logic [31:0] word;

		// Directed: empty pop, extreme words, fill both stacks, refuse, drain one
		add_req(tsfq_pkg::OP_POP, 32'h0, $urandom_range(0, 14), 1'b0);
		add_req(tsfq_pkg::OP_PUSH, 32'h0000_0000, $urandom_range(0, 14), 1'b0);
		add_req(tsfq_pkg::OP_PUSH, 32'hFFFF_FFFF, $urandom_range(0, 14), 1'b0);
		add_req(tsfq_pkg::OP_POP, $urandom(), $urandom_range(0, 14), 1'b0);
		add_req(tsfq_pkg::OP_POP, $urandom(), $urandom_range(0, 14), 1'b0);
		add_req(tsfq_pkg::OP_POP, 32'hFFFF_FFFF, $urandom_range(0, 14), 1'b0);
		for (int i = 0; i < 2 * DEPTH; i++)
			add_req(tsfq_pkg::OP_PUSH, (i % 2) ? $urandom() : ~32'(i),
				$urandom_range(0, 14), 1'b0);
		add_req(tsfq_pkg::OP_PUSH, 32'hA5A5_5A5A, $urandom_range(0, 14), 1'b0);
		add_req(tsfq_pkg::OP_POP, 32'h0, $urandom_range(0, 14), 1'b0);

		// Random: segments biased toward filling, draining or balance
		pop_pct  = 50;
		gap_mode = 1;
		for (int i = 0; i < RAND_REQS; i++) begin
			if (i % 50 == 0) begin
				case ($urandom_range(0, 2))
					0: pop_pct = 25;
					1: pop_pct = 75;
					default: pop_pct = 50;
				endcase
				gap_mode = $urandom_range(0, 2);
			end
			case (gap_mode)
				0: gap = 0;
				1: gap = $urandom_range(0, 14);
				default: gap = $urandom_range(0, 2);
			endcase
			// keep offering back to back while the receiver holds off
			if (i >= HOLD_AT - 60 && i <= HOLD_AT + 60)
				gap = 0;
			case ($urandom_range(0, 7))
				0: word = 32'h0;
				1: word = 32'hFFFF_FFFF;
				default: word = $urandom();
			endcase
			add_req(($urandom_range(1, 100) <= pop_pct) ? tsfq_pkg::OP_POP : tsfq_pkg::OP_PUSH,
				word, gap, i == 700 || i == 1200);
		end

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		wait (taken_reqs == total_reqs);
		wait (expected_results.size() == 0);
		repeat (DEPTH + 8) @(posedge clk);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
